@@ hw/rtl/hss_pkg.sv @@
// Shared constants, types and helper functions of the Hammersley sphere point block.
// No dependencies; every other file refers to this package by scoped names.
`default_nettype none
package hss_pkg;

    localparam int INDEX_BITS   = 16;
    localparam int FRAC_BITS    = 15;
    localparam int IDX_W        = 16;
    localparam int CNT_W        = 16;
    localparam int NEFF_W       = 17;
    localparam int FRONT_STEPS  = 31;
    localparam int N_TERMS      = 8;
    localparam int TERM_STAGES  = 3 * N_TERMS;
    localparam int RECIP_SHIFT  = 33;
    localparam int WDIV_STEPS   = 34;

    localparam logic [30:0] HALF_PI_Q30 = 31'd1686629713;
    localparam logic [33:0] FOUR_PI_Q30 = 34'd13493037705;
    localparam logic [19:0] WEIGHT_MAX  = 20'hFFFFF;
    localparam logic [30:0] ONE_Q30     = 31'h4000_0000;

    typedef enum logic [1:0] {
        CFG_SAMPLE_COUNT = 2'd0,
        CFG_HEMISPHERE   = 2'd1
    } t_cfg_reg;

    typedef struct packed {
        logic        inv;
        logic [15:0] oy;
        logic [30:0] sint;
    } t_side;

    // radical inverse of the index as a Q31 fraction
    function automatic logic [30:0] radical_q31(input logic [IDX_W-1:0] idx);
        logic [63:0]           ix;
        logic [INDEX_BITS-1:0] rev;
        logic [63:0]           wide;
        ix = 64'(idx);
        for (int i = 0; i < INDEX_BITS; i++) begin
            rev[INDEX_BITS-1-i] = ix[i];
        end
        if (INDEX_BITS <= 31) begin
            wide = 64'(rev) << ((31 - INDEX_BITS) & 63);
        end else begin
            wide = 64'(rev) >> ((INDEX_BITS - 31) & 63);
        end
        return wide[30:0];
    endfunction

    // Q30 to output format: round half away from zero, saturate
    function automatic logic [15:0] to_out(input logic signed [33:0] v);
        logic        neg;
        logic [33:0] mag;
        logic [63:0] m;
        neg = v[33];
        mag = neg ? 34'(-v) : 34'(v);
        m   = 64'(mag);
        if (FRAC_BITS < 30) begin
            m = (m + (64'd1 << ((29 - FRAC_BITS) & 63))) >> ((30 - FRAC_BITS) & 63);
        end else begin
            m = m << ((FRAC_BITS - 30) & 63);
        end
        if (neg) begin
            if (m > 64'd32768) m = 64'd32768;
            return 16'(17'h10000 - 17'(m));
        end
        if (m > 64'd32767) m = 64'd32767;
        return 16'(m);
    endfunction

    function automatic int sin_div(input int n);
        return (2 * n) * (2 * n + 1);
    endfunction

    function automatic int cos_div(input int n);
        return (2 * n - 1) * (2 * n);
    endfunction

endpackage
`default_nettype wire

@@ hw/rtl/hss_weight.sv @@
// Sequential divider for the solid-angle weight, run after reset and each register write.
// Depends on hss_pkg.
`default_nettype none
module hss_weight (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_start,
    input  wire logic [hss_pkg::NEFF_W-1:0]  i_neff,
    output logic                             o_busy,
    output logic [19:0]                      o_weight
);
    typedef enum logic {ST_IDLE, ST_RUN} t_state;

    t_state      r_state;
    logic [33:0] r_num;
    logic [30:0] r_den;
    logic [30:0] r_rem;
    logic [33:0] r_quo;
    logic [5:0]  r_cnt;
    logic        r_zero;
    logic [19:0] r_weight;

    logic [31:0] trial;
    logic        ge;
    logic [33:0] n_quo;

    always_comb begin
        trial = {r_rem, r_num[33]};
        ge    = trial >= 32'(r_den);
        n_quo = {r_quo[32:0], ge};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else if (i_start) begin
            r_state <= ST_RUN;
            r_num   <= hss_pkg::FOUR_PI_Q30 + (34'(i_neff) << 13);
            r_den   <= 31'(i_neff) << 14;
            r_rem   <= '0;
            r_quo   <= '0;
            r_cnt   <= 6'(hss_pkg::WDIV_STEPS);
            r_zero  <= (i_neff == '0);
        end else begin
            unique case (r_state)
                ST_IDLE: begin
                end
                ST_RUN: begin
                    r_rem <= ge ? 31'(trial - 32'(r_den)) : trial[30:0];
                    r_quo <= n_quo;
                    r_num <= {r_num[32:0], 1'b0};
                    r_cnt <= r_cnt - 6'd1;
                    if (r_cnt == 6'd1) begin
                        r_state  <= ST_IDLE;
                        r_weight <= (r_zero || n_quo > 34'(hss_pkg::WEIGHT_MAX))
                                    ? hss_pkg::WEIGHT_MAX : n_quo[19:0];
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign o_busy   = (r_state == ST_RUN);
    assign o_weight = r_weight;
endmodule
`default_nettype wire

@@ hw/rtl/hss_front.sv @@
// Front pipeline: azimuth divider and height square root, one bit per stage, in step.
// Depends on hss_pkg.
`default_nettype none
module hss_front (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_en,
    input  wire logic                        i_valid,
    input  wire logic [hss_pkg::IDX_W-1:0]   i_idx,
    input  wire logic                        i_inv,
    input  wire logic [hss_pkg::NEFF_W-1:0]  i_neff,
    output logic                             o_valid,
    output logic [31:0]                      o_t32,
    output hss_pkg::t_side                   o_side
);
    localparam int LAST = hss_pkg::FRONT_STEPS;

    logic                       r_v   [0:LAST];
    logic [31:0]                r_q   [0:LAST];
    logic [hss_pkg::NEFF_W-1:0] r_rem [0:LAST];
    logic [60:0]                r_rad [0:LAST];
    logic [60:0]                r_res [0:LAST];
    logic [15:0]                r_oy  [0:LAST];
    logic                       r_inv [0:LAST];

    // first stage: integer quotient bit, radicand 1 - h*h and the output height
    logic [hss_pkg::NEFF_W-1:0] m;
    logic                       qi;
    logic [30:0]                r31;
    logic signed [32:0]         h30;
    logic [30:0]                hm;
    logic [61:0]                sq;

    always_comb begin
        m   = {i_idx, 1'b1};
        qi  = m >= i_neff;
        r31 = hss_pkg::radical_q31(i_idx);
        h30 = signed'({2'b00, r31}) - signed'(33'(hss_pkg::ONE_Q30));
        hm  = h30[32] ? 31'(-h30) : 31'(h30);
        sq  = 62'(hm) * 62'(hm);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v[0] <= 1'b0;
        end else if (i_en) begin
            r_v[0] <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_q[0]   <= {31'd0, qi};
            r_rem[0] <= qi ? m - i_neff : m;
            r_rad[0] <= (61'd1 << 60) - sq[60:0];
            r_res[0] <= '0;
            r_oy[0]  <= hss_pkg::to_out(34'(h30));
            r_inv[0] <= i_inv;
        end
    end

    for (genvar k = 1; k <= LAST; k++) begin : g_step
        localparam logic [60:0] BIT = 61'd1 << (2 * (LAST - k));

        logic [hss_pkg::NEFF_W:0] t;
        logic                     b;
        logic [61:0]              sum;
        logic                     ge;

        always_comb begin
            t   = {r_rem[k-1], 1'b0};
            b   = t >= {1'b0, i_neff};
            sum = 62'(r_res[k-1]) + 62'(BIT);
            ge  = {1'b0, r_rad[k-1]} >= sum;
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k] <= 1'b0;
            end else if (i_en) begin
                r_v[k] <= r_v[k-1];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_q[k]   <= {r_q[k-1][30:0], b};
                r_rem[k] <= b ? hss_pkg::NEFF_W'(t - {1'b0, i_neff})
                              : t[hss_pkg::NEFF_W-1:0];
                r_rad[k] <= ge ? r_rad[k-1] - sum[60:0] : r_rad[k-1];
                r_res[k] <= ge ? (r_res[k-1] >> 1) + BIT : r_res[k-1] >> 1;
                r_oy[k]  <= r_oy[k-1];
                r_inv[k] <= r_inv[k-1];
            end
        end
    end

    assign o_valid     = r_v[LAST];
    assign o_t32       = r_q[LAST];
    assign o_side.inv  = r_inv[LAST];
    assign o_side.oy   = r_oy[LAST];
    assign o_side.sint = r_res[LAST][30:0];
endmodule
`default_nettype wire

@@ hw/rtl/hss_sincos.sv @@
// Sine and cosine pipeline: angle scaling, then three stages per Taylor term.
// Depends on hss_pkg.
`default_nettype none
module hss_sincos (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_en,
    input  wire logic               i_valid,
    input  wire logic [31:0]        i_t32,
    input  wire hss_pkg::t_side     i_side,
    output logic                    o_valid,
    output logic signed [33:0]      o_sin,
    output logic signed [33:0]      o_cos,
    output logic [1:0]              o_quad,
    output hss_pkg::t_side          o_side
);
    localparam int NS = hss_pkg::TERM_STAGES;

    typedef struct packed {
        logic [31:0]        x2;
        logic [31:0]        ts;
        logic [31:0]        tc;
        logic [31:0]        es;
        logic [31:0]        ec;
        logic signed [33:0] ss;
        logic signed [33:0] cs;
        logic [1:0]         quad;
        hss_pkg::t_side     side;
    } t_sc;

    logic           r_a_v;
    logic [30:0]    r_a_x;
    logic [1:0]     r_a_quad;
    hss_pkg::t_side r_a_side;

    logic           r_v  [0:NS];
    t_sc            r_st [0:NS];

    logic [60:0] px;
    logic [61:0] px2;

    assign px  = 61'(i_t32[29:0]) * 61'(hss_pkg::HALF_PI_Q30);
    assign px2 = 62'(r_a_x) * 62'(r_a_x);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_v <= 1'b0;
            r_v[0] <= 1'b0;
        end else if (i_en) begin
            r_a_v  <= i_valid;
            r_v[0] <= r_a_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_a_x         <= px[60:30];
            r_a_quad      <= i_t32[31:30];
            r_a_side      <= i_side;
            r_st[0].x2    <= px2[61:30];
            r_st[0].ts    <= 32'(r_a_x);
            r_st[0].tc    <= 32'(hss_pkg::ONE_Q30);
            r_st[0].es    <= '0;
            r_st[0].ec    <= '0;
            r_st[0].ss    <= signed'(34'(r_a_x));
            r_st[0].cs    <= signed'(34'(hss_pkg::ONE_Q30));
            r_st[0].quad  <= r_a_quad;
            r_st[0].side  <= r_a_side;
        end
    end

    for (genvar j = 1; j <= NS; j++) begin : g_term
        localparam int N  = (j - 1) / 3 + 1;
        localparam int PH = (j - 1) % 3;
        localparam int DS = hss_pkg::sin_div(N);
        localparam int DC = hss_pkg::cos_div(N);
        localparam logic [32:0] RS = 33'((64'd1 << hss_pkg::RECIP_SHIFT) / 64'(DS));
        localparam logic [32:0] RC = 33'((64'd1 << hss_pkg::RECIP_SHIFT) / 64'(DC));

        t_sc         n_st;
        logic [63:0] ps, pc;
        logic [64:0] es, ec;
        logic [41:0] rs, rc;
        logic [31:0] qs, qc;

        always_comb begin
            n_st = r_st[j-1];
            ps   = 64'(r_st[j-1].ts) * 64'(r_st[j-1].x2);
            pc   = 64'(r_st[j-1].tc) * 64'(r_st[j-1].x2);
            es   = 65'(r_st[j-1].ts) * 65'(RS);
            ec   = 65'(r_st[j-1].tc) * 65'(RC);
            rs   = 42'(r_st[j-1].ts) - 42'(r_st[j-1].es) * 42'(DS);
            rc   = 42'(r_st[j-1].tc) - 42'(r_st[j-1].ec) * 42'(DC);
            qs   = r_st[j-1].es + 32'(rs >= 42'(DS));
            qc   = r_st[j-1].ec + 32'(rc >= 42'(DC));
            if (PH == 0) begin
                // next power of the angle
                n_st.ts = ps[61:30];
                n_st.tc = pc[61:30];
            end else if (PH == 1) begin
                // quotient estimate by reciprocal, may be one short
                n_st.es = es[64:33];
                n_st.ec = ec[64:33];
            end else begin
                n_st.ts = qs;
                n_st.tc = qc;
                if (N % 2 == 1) begin
                    n_st.ss = r_st[j-1].ss - signed'({2'b00, qs});
                    n_st.cs = r_st[j-1].cs - signed'({2'b00, qc});
                end else begin
                    n_st.ss = r_st[j-1].ss + signed'({2'b00, qs});
                    n_st.cs = r_st[j-1].cs + signed'({2'b00, qc});
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[j] <= 1'b0;
            end else if (i_en) begin
                r_v[j] <= r_v[j-1];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_st[j] <= n_st;
            end
        end
    end

    assign o_valid = r_v[NS];
    assign o_sin   = r_st[NS].ss;
    assign o_cos   = r_st[NS].cs;
    assign o_quad  = r_st[NS].quad;
    assign o_side  = r_st[NS].side;
endmodule
`default_nettype wire

@@ hw/rtl/hammersley_sphere_point.sv @@
// Top level of the Hammersley sphere point generator: registers, pipeline, output stage.
// Depends on hss_pkg, hss_weight, hss_front and hss_sincos.
//
// Usage:
//   Input channel: i_in_valid, o_in_stall, i_sample_index. An item is taken at a
//   rising edge with i_in_valid high and o_in_stall low.
//   Output channel: o_out_valid, i_out_stall and the point fields; an item leaves
//   at an edge with o_out_valid high and i_out_stall low.
//   Register port: i_cfg_valid, o_cfg_ready (always high), i_cfg_index, i_cfg_data.
//   Index 0 is the sample count, index 1 the hemisphere mode; others are dropped.
//   Throughput: one item per cycle while o_in_stall is low. From acceptance an item
//   passes the input register, the 31-step divider and square root lanes, the angle
//   scaling, the eight Taylor terms of three stages each and the output stage.
//   Reset and every register write start the weight divider; o_in_stall is held high
//   while the start is pending and while the divider runs. Reset clears all valid bits.
//   When the receiver stalls with a result waiting, the whole pipeline holds and
//   o_in_stall rises; nothing is dropped or repeated.
`default_nettype none
module hammersley_sphere_point (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic [15:0] i_sample_index,
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic [15:0]      o_pos_x,
    output logic [15:0]      o_pos_y,
    output logic [15:0]      o_pos_z,
    output logic [19:0]      o_solid_angle_weight,
    output logic             o_index_invalid,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [1:0]  i_cfg_index,
    input  wire logic [15:0] i_cfg_data
);
    // configuration registers
    logic [hss_pkg::CNT_W-1:0]  r_count;
    logic                       r_hemi;
    logic                       r_kick;
    logic [hss_pkg::NEFF_W-1:0] neff;
    logic                       cfg_we;

    // pipeline control: advance whenever the output register can move
    logic en;
    logic accept;

    logic                      r_in_v;
    logic [hss_pkg::IDX_W-1:0] r_in_idx;
    logic                      r_in_inv;

    logic           f_valid;
    logic [31:0]    f_t32;
    hss_pkg::t_side f_side;

    logic               s_valid;
    logic signed [33:0] s_sin, s_cos;
    logic [1:0]         s_quad;
    hss_pkg::t_side     s_side;

    logic               r_p_v;
    logic signed [33:0] r_p_px, r_p_pz;
    hss_pkg::t_side     r_p_side;

    logic        w_busy;
    logic [19:0] w_weight;

    logic        r_out_v;
    logic [15:0] r_out_x, r_out_y, r_out_z;
    logic        r_out_inv;

    assign o_cfg_ready = 1'b1;
    assign cfg_we      = i_cfg_valid && o_cfg_ready;
    assign neff        = r_hemi ? {r_count, 1'b0} : {1'b0, r_count};

    assign en         = !(r_out_v && i_out_stall);
    assign o_in_stall = !en || r_kick || w_busy;
    assign accept     = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= 16'd256;
            r_hemi  <= 1'b0;
            r_kick  <= 1'b1;
        end else begin
            r_kick <= cfg_we;
            if (cfg_we) begin
                unique case (hss_pkg::t_cfg_reg'(i_cfg_index))
                    hss_pkg::CFG_SAMPLE_COUNT: r_count <= i_cfg_data;
                    hss_pkg::CFG_HEMISPHERE:   r_hemi  <= i_cfg_data[0];
                    default: begin
                    end
                endcase
            end
        end
    end

    hss_weight u_weight (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (r_kick),
        .i_neff   (neff),
        .o_busy   (w_busy),
        .o_weight (w_weight)
    );

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_v <= 1'b0;
        end else if (en) begin
            r_in_v <= accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_in_idx <= i_sample_index;
            r_in_inv <= i_sample_index >= r_count;
        end
    end

    hss_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_in_v),
        .i_idx   (r_in_idx),
        .i_inv   (r_in_inv),
        .i_neff  (neff),
        .o_valid (f_valid),
        .o_t32   (f_t32),
        .o_side  (f_side)
    );

    hss_sincos u_sincos (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (f_valid),
        .i_t32   (f_t32),
        .i_side  (f_side),
        .o_valid (s_valid),
        .o_sin   (s_sin),
        .o_cos   (s_cos),
        .o_quad  (s_quad),
        .o_side  (s_side)
    );

    // quadrant fold, then scale by the ring radius, truncating toward zero
    logic signed [33:0] sv, cv;
    logic [33:0]        mag_s, mag_c;
    logic [64:0]        prod_s, prod_c;
    logic [33:0]        m_s, m_c;

    always_comb begin
        case (s_quad)
            2'd0: begin sv = s_sin;  cv = s_cos;  end
            2'd1: begin sv = s_cos;  cv = -s_sin; end
            2'd2: begin sv = -s_sin; cv = -s_cos; end
            default: begin sv = -s_cos; cv = s_sin; end
        endcase
        mag_s  = sv[33] ? 34'(-sv) : 34'(sv);
        mag_c  = cv[33] ? 34'(-cv) : 34'(cv);
        prod_s = 65'(s_side.sint) * 65'(mag_s);
        prod_c = 65'(s_side.sint) * 65'(mag_c);
        m_s    = prod_s[63:30];
        m_c    = prod_c[63:30];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_v <= 1'b0;
        end else if (en) begin
            r_p_v <= s_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_p_px   <= cv[33] ? -signed'(m_c) : signed'(m_c);
            r_p_pz   <= sv[33] ? signed'(m_s) : -signed'(m_s);
            r_p_side <= s_side;
        end
    end

    // output register: round, saturate, zero the coordinates of an invalid index
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (en) begin
            r_out_v <= r_p_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out_x   <= r_p_side.inv ? 16'd0 : hss_pkg::to_out(r_p_px);
            r_out_y   <= r_p_side.inv ? 16'd0 : r_p_side.oy;
            r_out_z   <= r_p_side.inv ? 16'd0 : hss_pkg::to_out(r_p_pz);
            r_out_inv <= r_p_side.inv;
        end
    end

    assign o_out_valid          = r_out_v;
    assign o_pos_x              = r_out_x;
    assign o_pos_y              = r_out_y;
    assign o_pos_z              = r_out_z;
    assign o_solid_angle_weight = w_weight;
    assign o_index_invalid      = r_out_inv;

    a_cfg_holds_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cfg_we |=> o_in_stall)
        else $error("input taken right after a register write");

    a_reset_holds_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(!i_rst_n) |-> o_in_stall)
        else $error("input taken before the weight is known");

    a_invalid_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_index_invalid |->
            o_pos_x == 16'd0 && o_pos_y == 16'd0 && o_pos_z == 16'd0)
        else $error("invalid index gave a nonzero point");

    a_weight_steady: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_kick && !w_busy |=> $stable(w_weight))
        else $error("weight changed while the divider was idle");
endmodule
`default_nettype wire
